FILE: design/c_subset_lexer_defines.svh
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// check that holds at every edge once out of reset
`define CSL_ASSERT_NOW(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// check that a condition leads to another in the next cycle
`define CSL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/csl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csl_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [3:0]  operator_code;
      logic [15:0] start_pos;
      logic [15:0] token_length;
      logic [30:0] number_value;
      logic        run_end;
   } rsp_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_IDENT,
      MODE_OPPEND,
      MODE_SKIP
   } mode_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] code;
   } op_hit_type;

   localparam logic [3:0] KIND_OP     = 4'd0;
   localparam logic [3:0] KIND_NUM    = 4'd1;
   localparam logic [3:0] KIND_IDENT  = 4'd2;
   localparam logic [3:0] KIND_RETURN = 4'd3;
   localparam logic [3:0] KIND_IF     = 4'd4;
   localparam logic [3:0] KIND_ELSE   = 4'd5;
   localparam logic [3:0] KIND_WHILE  = 4'd6;
   localparam logic [3:0] KIND_FOR    = 4'd7;
   localparam logic [3:0] KIND_END    = 4'd8;
   localparam logic [3:0] KIND_ERR    = 4'd9;

   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_EQ   = 4'd12;
   localparam logic [3:0] OP_NE   = 4'd13;
   localparam logic [3:0] OP_LE   = 4'd14;
   localparam logic [3:0] OP_GE   = 4'd15;

   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam int OP_COUNT = 12;
   // + - * / ( ) < > ; = { }
   localparam logic [7:0] OP_CHARS [OP_COUNT] = '{
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29,
      8'h3C, 8'h3E, 8'h3B, 8'h3D, 8'h7B, 8'h7D
   };

   localparam logic [47:0] KW_RETURN = 48'h72657475726E;
   localparam logic [47:0] KW_IF     = 48'h000000006966;
   localparam logic [47:0] KW_ELSE   = 48'h0000656C7365;
   localparam logic [47:0] KW_WHILE  = 48'h007768696C65;
   localparam logic [47:0] KW_FOR    = 48'h000000666F72;

   localparam logic [30:0] NUM_MAX   = 31'h7FFFFFFF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // result queue
   localparam int RES_DEPTH = 4;
   localparam int RES_PTR_W = 2;
   localparam int MAX_RES   = 3;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   function automatic logic is_word(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
         || is_digit(b) || (b == 8'h5F);
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic op_hit_type op_lookup(input logic [7:0] b);
      op_hit_type r;
      r = '0;
      for (int i = 0; i < OP_COUNT; i++) begin
         if (OP_CHARS[i] == b) begin
            r.hit  = 1'b1;
            r.code = 4'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [3:0] ident_kind(input logic [47:0] win, input logic [15:0] cnt);
      logic [3:0] k;
      k = KIND_IDENT;
      if (cnt == 16'd6 && win == KW_RETURN) k = KIND_RETURN;
      if (cnt == 16'd2 && win == KW_IF)     k = KIND_IF;
      if (cnt == 16'd4 && win == KW_ELSE)   k = KIND_ELSE;
      if (cnt == 16'd5 && win == KW_WHILE)  k = KIND_WHILE;
      if (cnt == 16'd3 && win == KW_FOR)    k = KIND_FOR;
      return k;
   endfunction

   function automatic rsp_type make_word(input logic [3:0] kind, input logic [3:0] op,
                                         input logic [15:0] start, input logic [15:0] len,
                                         input logic [30:0] val);
      rsp_type w;
      w.token_kind    = kind;
      w.operator_code = op;
      w.start_pos     = start;
      w.token_length  = len;
      w.number_value  = val;
      w.run_end       = 1'b0;
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: design/c_subset_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming tokenizer for a small C subset. One text byte is taken per clock while
// req_ready is high; the tokens it completes (none to three, the last one flagged with
// run_end) are written at once into a four-word result queue that drains one word per
// cycle on the rsp side while rsp_ready is high. req_ready is high while the queue holds
// at most one word, so with rsp_ready held high a text with one token per byte or fewer
// runs at one byte per cycle; a byte that closes several tokens holds off further bytes
// until the single read port drains the queue to one word. Positions saturate at
// MAX_TEXT_LEN and are reported modulo 65536. After an error token the rest of the text
// is swallowed and the final byte returns the lexer to its reset state.

`include "c_subset_lexer_defines.svh"

module c_subset_lexer
   import csl_pkg::*;
#(
   parameter int MAX_TEXT_LEN = 65535
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_word,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_word
);

   localparam int POS_W = $clog2(MAX_TEXT_LEN + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_LEN);

   mode_type         mode_ff,   mode_in;
   logic [7:0]       pend_ff,   pend_in;
   logic [15:0]      start_ff,  start_in;
   logic [15:0]      count_ff,  count_in;
   logic [30:0]      accum_ff,  accum_in;
   logic [47:0]      window_ff, window_in;
   logic [POS_W-1:0] pos_ff,    pos_in;

   rsp_type              fifo_mem [RES_DEPTH];
   logic [RES_PTR_W-1:0] wr_ff, wr_in;
   logic [RES_PTR_W-1:0] rd_ff, rd_in;
   logic [RES_PTR_W:0]   fill_ff, fill_in;

   rsp_type    res_w [MAX_RES];
   logic [1:0] push_n;
   logic       req_fire;
   logic       rsp_fire;

   logic [RES_PTR_W:0] push_w;
   logic [RES_PTR_W:0] pop_w;

   logic [POS_W-1:0]  pos_nx;
   logic [POS_W+15:0] pos_ext;
   logic [POS_W+15:0] pos_nx_ext;
   logic [15:0]       pos16;
   logic [15:0]       pos_nx16;
   logic [34:0]       acc_mul;
   logic [7:0]        b;
   logic              fin;
   logic              used;
   op_hit_type        op_b;
   op_hit_type        op_p;
   op_hit_type        op_f;

   assign req_ready = fill_ff <= (RES_PTR_W + 1)'(RES_DEPTH - MAX_RES);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = fill_ff != '0;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_word  = fifo_mem[rd_ff];

   assign b   = req_word.text_byte;
   assign fin = req_word.final_byte;

   assign pos_nx     = (pos_ff >= POS_MAX) ? POS_MAX : pos_ff + 1'b1;
   assign pos_ext    = {16'b0, pos_ff};
   assign pos_nx_ext = {16'b0, pos_nx};
   assign pos16      = pos_ext[15:0];
   assign pos_nx16   = pos_nx_ext[15:0];
   // accum * 10 + digit, by shift and add
   assign acc_mul = {1'b0, accum_ff, 3'b0} + {3'b0, accum_ff, 1'b0} + 35'(b - CH_ZERO);
   assign op_b = op_lookup(b);
   assign op_p = op_lookup(pend_ff);

   assign push_w = (RES_PTR_W + 1)'(push_n);
   assign pop_w  = (RES_PTR_W + 1)'(rsp_fire);

   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      start_in  = start_ff;
      count_in  = count_ff;
      accum_in  = accum_ff;
      window_in = window_ff;
      pos_in    = pos_ff;
      used      = 1'b0;
      push_n    = 2'd0;
      op_f      = '0;
      for (int i = 0; i < MAX_RES; i++) res_w[i] = '0;

      if (req_fire) begin
         if (mode_ff == MODE_SKIP) begin
            if (fin) begin
               mode_in   = MODE_IDLE;
               pend_in   = '0;
               start_in  = '0;
               count_in  = '0;
               accum_in  = '0;
               window_in = '0;
               pos_in    = '0;
            end else begin
               pos_in = pos_nx;
            end
         end else begin
            // close or extend the open token
            unique case (mode_ff)
               MODE_NUM: begin
                  if (is_digit(b)) begin
                     accum_in = (acc_mul > {4'b0, NUM_MAX}) ? NUM_MAX : acc_mul[30:0];
                     if (count_ff != COUNT_MAX) count_in = count_ff + 16'd1;
                     used = 1'b1;
                  end else begin
                     res_w[push_n] = make_word(KIND_NUM, OP_NONE, start_ff, count_ff, accum_ff);
                     push_n  = push_n + 2'd1;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_IDENT: begin
                  if (is_word(b)) begin
                     window_in = {window_ff[39:0], b};
                     if (count_ff != COUNT_MAX) count_in = count_ff + 16'd1;
                     used = 1'b1;
                  end else begin
                     res_w[push_n] = make_word(ident_kind(window_ff, count_ff), OP_NONE,
                                               start_ff, count_ff, '0);
                     push_n  = push_n + 2'd1;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_OPPEND: begin
                  if (b == CH_EQUAL) begin
                     priority if (pend_ff == CH_EQUAL) begin
                        res_w[push_n] = make_word(KIND_OP, OP_EQ, start_ff, 16'd2, '0);
                     end else if (pend_ff == CH_BANG) begin
                        res_w[push_n] = make_word(KIND_OP, OP_NE, start_ff, 16'd2, '0);
                     end else if (pend_ff == CH_LT) begin
                        res_w[push_n] = make_word(KIND_OP, OP_LE, start_ff, 16'd2, '0);
                     end else begin
                        res_w[push_n] = make_word(KIND_OP, OP_GE, start_ff, 16'd2, '0);
                     end
                     push_n  = push_n + 2'd1;
                     mode_in = MODE_IDLE;
                     used    = 1'b1;
                  end else if (pend_ff == CH_BANG) begin
                     // lone '!' is an error and kills the rest of the text
                     res_w[push_n] = make_word(KIND_ERR, OP_NONE, start_ff, 16'd1, '0);
                     push_n  = push_n + 2'd1;
                     mode_in = MODE_SKIP;
                     used    = 1'b1;
                  end else begin
                     res_w[push_n] = make_word(KIND_OP, op_p.code, start_ff, 16'd1, '0);
                     push_n  = push_n + 2'd1;
                     mode_in = MODE_IDLE;
                  end
               end
               default: begin
               end
            endcase

            // byte starts something new
            if (!used && mode_in == MODE_IDLE) begin
               priority if (is_space(b)) begin
               end else if (is_digit(b)) begin
                  mode_in  = MODE_NUM;
                  start_in = pos16;
                  count_in = 16'd1;
                  accum_in = 31'(b - CH_ZERO);
               end else if (is_word(b)) begin
                  mode_in   = MODE_IDENT;
                  start_in  = pos16;
                  count_in  = 16'd1;
                  window_in = {40'b0, b};
               end else if (b == CH_LT || b == CH_GT || b == CH_EQUAL || b == CH_BANG) begin
                  mode_in  = MODE_OPPEND;
                  pend_in  = b;
                  start_in = pos16;
               end else if (op_b.hit) begin
                  res_w[push_n] = make_word(KIND_OP, op_b.code, pos16, 16'd1, '0);
                  push_n = push_n + 2'd1;
               end else begin
                  res_w[push_n] = make_word(KIND_ERR, OP_NONE, pos16, 16'd1, '0);
                  push_n  = push_n + 2'd1;
                  mode_in = MODE_SKIP;
               end
            end

            if (fin) begin
               unique case (mode_in)
                  MODE_NUM: begin
                     res_w[push_n] = make_word(KIND_NUM, OP_NONE, start_in, count_in, accum_in);
                     push_n = push_n + 2'd1;
                  end
                  MODE_IDENT: begin
                     res_w[push_n] = make_word(ident_kind(window_in, count_in), OP_NONE,
                                               start_in, count_in, '0);
                     push_n = push_n + 2'd1;
                  end
                  MODE_OPPEND: begin
                     if (pend_in == CH_BANG) begin
                        res_w[push_n] = make_word(KIND_ERR, OP_NONE, start_in, 16'd1, '0);
                        mode_in = MODE_SKIP;
                     end else begin
                        op_f = op_lookup(pend_in);
                        res_w[push_n] = make_word(KIND_OP, op_f.code, start_in, 16'd1, '0);
                     end
                     push_n = push_n + 2'd1;
                  end
                  default: begin
                  end
               endcase
               if (mode_in != MODE_SKIP) begin
                  res_w[push_n] = make_word(KIND_END, OP_NONE, pos_nx16, 16'd0, '0);
                  push_n = push_n + 2'd1;
               end
               mode_in   = MODE_IDLE;
               pend_in   = '0;
               start_in  = '0;
               count_in  = '0;
               accum_in  = '0;
               window_in = '0;
               pos_in    = '0;
            end else begin
               pos_in = pos_nx;
            end
         end
      end

      if (push_n != 2'd0) res_w[push_n - 2'd1].run_end = 1'b1;
   end

   always_comb begin
      wr_in   = wr_ff + RES_PTR_W'(push_n);
      rd_in   = rsp_fire ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + push_w - pop_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pend_ff   <= '0;
         start_ff  <= '0;
         count_ff  <= '0;
         accum_ff  <= '0;
         window_ff <= '0;
         pos_ff    <= '0;
         wr_ff     <= '0;
         rd_ff     <= '0;
         fill_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         start_ff  <= start_in;
         count_ff  <= count_in;
         accum_ff  <= accum_in;
         window_ff <= window_in;
         pos_ff    <= pos_in;
         wr_ff     <= wr_in;
         rd_ff     <= rd_in;
         fill_ff   <= fill_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (2'(i) < push_n) fifo_mem[wr_ff + RES_PTR_W'(i)] <= res_w[i];
      end
   end

   `CSL_ASSERT_NOW(a_fill_bound, fill_ff <= (RES_PTR_W + 1)'(RES_DEPTH), "result queue overflow")
   `CSL_ASSERT_NEXT(a_fill_track, 1'b1, fill_ff == $past(fill_ff + push_w - pop_w), "fill drift")
   `CSL_ASSERT_NOW(a_skip_silent, !(req_fire && mode_ff == MODE_SKIP) || push_n == 2'd0, "token after error")
   `CSL_ASSERT_NEXT(a_final_clears, req_fire && fin, mode_ff == MODE_IDLE && pos_ff == '0, "no restart")

endmodule

`default_nettype wire

FILE: tb/sv/tb_c_subset_lexer.sv
`timescale 1ns / 1ps

module tb_c_subset_lexer;
   import csl_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int TOTAL_ITEMS = 430;

   // tracks the lexer state and the token words still owed by the block
   class token_scoreboard;
      rsp_type     expected[$];
      rsp_type     fresh[$];
      int          fails;
      mode_type    mode;
      logic [7:0]  pend;
      logic [15:0] tok_start;
      logic [15:0] tok_len;
      logic [15:0] pos;
      logic [30:0] num;
      logic [47:0] win;

      function new();
         fails = 0;
         clear();
      endfunction

      function void clear();
         mode      = MODE_IDLE;
         pend      = '0;
         tok_start = '0;
         tok_len   = '0;
         pos       = '0;
         num       = '0;
         win       = '0;
      endfunction

      function logic [15:0] next_pos(input logic [15:0] p);
         return (p == 16'hFFFF) ? p : p + 16'd1;
      endfunction

      function bit digit_char(input logic [7:0] b);
         return b >= "0" && b <= "9";
      endfunction

      function bit word_char(input logic [7:0] b);
         if (b >= "a" && b <= "z") return 1'b1;
         if (b >= "A" && b <= "Z") return 1'b1;
         return digit_char(b) || b == "_";
      endfunction

      function bit blank_char(input logic [7:0] b);
         return b == " " || (b >= 8'd9 && b <= 8'd13);
      endfunction

      function int single_op(input logic [7:0] b);
         string ops;
         ops = "+-*/()<>;={}";
         for (int i = 0; i < ops.len(); i++)
            if (ops[i] == b) return i;
         return -1;
      endfunction

      function void emit(input logic [3:0] kind, input logic [3:0] op,
                         input logic [15:0] start, input logic [15:0] len,
                         input logic [30:0] val);
         rsp_type w;
         w.token_kind    = kind;
         w.operator_code = op;
         w.start_pos     = start;
         w.token_length  = len;
         w.number_value  = val;
         w.run_end       = 1'b0;
         fresh.push_back(w);
      endfunction

      function void emit_word_token();
         logic [3:0] k;
         k = KIND_IDENT;
         case (tok_len)
            16'd6: if (win == "return") k = KIND_RETURN;
            16'd2: if (win == "if") k = KIND_IF;
            16'd4: if (win == "else") k = KIND_ELSE;
            16'd5: if (win == "while") k = KIND_WHILE;
            16'd3: if (win == "for") k = KIND_FOR;
            default: ;
         endcase
         emit(k, OP_NONE, tok_start, tok_len, '0);
      endfunction

      // a held < > = or ! that did not get its '='
      function void flush_pend();
         if (pend == CH_BANG) begin
            emit(KIND_ERR, OP_NONE, tok_start, 16'd1, '0);
            mode = MODE_SKIP;
         end else begin
            emit(KIND_OP, 4'(single_op(pend)), tok_start, 16'd1, '0);
            mode = MODE_IDLE;
         end
      endfunction

      // returns 0 when the byte arrived while skipping after an earlier error
      function bit note_input(input req_type w);
         logic [7:0]  b;
         logic        fin;
         logic [15:0] at;
         logic [3:0]  code;
         bit          used;
         int          oi;
         longint      v;
         rsp_type     r;
         b    = w.text_byte;
         fin  = w.final_byte;
         at   = pos;
         used = 1'b0;
         fresh.delete();
         if (mode == MODE_SKIP) begin
            if (fin) clear();
            else pos = next_pos(at);
            return 1'b0;
         end
         case (mode)
            MODE_NUM: begin
               if (digit_char(b)) begin
                  v = longint'(num) * 10 + longint'(b - CH_ZERO);
                  num = (v > longint'(NUM_MAX)) ? NUM_MAX : v[30:0];
                  if (tok_len != 16'hFFFF) tok_len++;
                  used = 1'b1;
               end else begin
                  emit(KIND_NUM, OP_NONE, tok_start, tok_len, num);
                  mode = MODE_IDLE;
               end
            end
            MODE_IDENT: begin
               if (word_char(b)) begin
                  win = {win[39:0], b};
                  if (tok_len != 16'hFFFF) tok_len++;
                  used = 1'b1;
               end else begin
                  emit_word_token();
                  mode = MODE_IDLE;
               end
            end
            MODE_OPPEND: begin
               if (b == CH_EQUAL) begin
                  case (pend)
                     CH_EQUAL: code = OP_EQ;
                     CH_BANG:  code = OP_NE;
                     CH_LT:    code = OP_LE;
                     default:  code = OP_GE;
                  endcase
                  emit(KIND_OP, code, tok_start, 16'd2, '0);
                  mode = MODE_IDLE;
                  used = 1'b1;
               end else begin
                  flush_pend();
                  // the byte after a lone '!' is already part of the skipped tail
                  used = (mode == MODE_SKIP);
               end
            end
            default: ;
         endcase
         if (!used && mode == MODE_IDLE) begin
            oi = single_op(b);
            if (digit_char(b)) begin
               mode      = MODE_NUM;
               tok_start = at;
               tok_len   = 16'd1;
               num       = 31'(b - CH_ZERO);
            end else if (word_char(b)) begin
               mode      = MODE_IDENT;
               tok_start = at;
               tok_len   = 16'd1;
               win       = {40'd0, b};
            end else if (b == CH_LT || b == CH_GT || b == CH_EQUAL || b == CH_BANG) begin
               mode      = MODE_OPPEND;
               pend      = b;
               tok_start = at;
            end else if (oi >= 0) begin
               emit(KIND_OP, 4'(oi), at, 16'd1, '0);
            end else if (!blank_char(b)) begin
               emit(KIND_ERR, OP_NONE, at, 16'd1, '0);
               mode = MODE_SKIP;
            end
         end
         if (fin) begin
            case (mode)
               MODE_NUM:    emit(KIND_NUM, OP_NONE, tok_start, tok_len, num);
               MODE_IDENT:  emit_word_token();
               MODE_OPPEND: flush_pend();
               default: ;
            endcase
            if (mode != MODE_SKIP) emit(KIND_END, OP_NONE, next_pos(at), 16'd0, '0);
            clear();
         end else begin
            pos = next_pos(at);
         end
         foreach (fresh[i]) begin
            r = fresh[i];
            r.run_end = (i == fresh.size() - 1);
            expected.push_back(r);
         end
         return 1'b1;
      endfunction

      function void cmp_field(input string name, input logic [31:0] exp,
                              input logic [31:0] got);
         if (got !== exp) begin
            $error("%s: expected %0d, got %0d", name, exp, got);
            fails++;
         end
      endfunction

      function void check_result(input rsp_type got);
         rsp_type e;
         if (expected.size() == 0) begin
            $error("token word with none expected: kind %0d start %0d",
                   got.token_kind, got.start_pos);
            fails++;
            return;
         end
         e = expected.pop_front();
         cmp_field("token_kind", e.token_kind, got.token_kind);
         cmp_field("operator_code", e.operator_code, got.operator_code);
         cmp_field("start_pos", e.start_pos, got.start_pos);
         cmp_field("token_length", e.token_length, got.token_length);
         cmp_field("number_value", e.number_value, got.number_value);
         cmp_field("run_end", e.run_end, got.run_end);
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;

   token_scoreboard sb;
   logic [7:0] text_q[$];
   int         burst_left   = 0;
   int         live_items   = 0;
   int         stall_cycles = 0;
   int         rx_cycle     = 0;
   int         rx_seg_left  = 0;
   int         rx_seg_mode  = 0;
   bit         timed_out    = 1'b0;

   string keyword_names[5] = '{"return", "if", "else", "while", "for"};
   string pair_ops[4]      = '{"==", "!=", "<=", ">="};
   string op_chars         = "+-*/()<>;={}";

   c_subset_lexer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // receiver: stall pattern of its own plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_word);
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle >= 150 && rx_cycle < 310) begin
            rsp_ready <= 1'b0;
         end else begin
            if (rx_seg_left == 0) begin
               rx_seg_left = $urandom_range(4, 40);
               rx_seg_mode = $urandom_range(0, 2);
            end
            rx_seg_left = rx_seg_left - 1;
            case (rx_seg_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= $urandom_range(0, 1);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int      gap;
      req_type w;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      w.text_byte  = b;
      w.final_byte = fin;
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      void'(sb.note_input(w));
      live_items++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] rand_word_char(input bit lead);
      int r;
      r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   function automatic logic [7:0] rand_blank();
      int r;
      r = $urandom_range(8, 13);
      return (r == 8) ? " " : 8'(r);
   endfunction

   // mostly well-formed token streams, now and then a stray byte
   task automatic add_random_text();
      int n;
      int k;
      int len;
      n = $urandom_range(1, 12);
      repeat (n) begin
         k = $urandom_range(0, 19);
         if (k < 6) begin
            if ($urandom_range(0, 2) == 0) begin
               add_str(keyword_names[$urandom_range(0, 4)]);
               if ($urandom_range(0, 3) == 0) text_q.push_back(rand_word_char(1'b0));
            end else begin
               len = $urandom_range(1, 8);
               text_q.push_back(rand_word_char(1'b1));
               repeat (len - 1) text_q.push_back(rand_word_char(1'b0));
            end
         end else if (k < 10) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
            repeat (len) text_q.push_back(8'("0" + $urandom_range(0, 9)));
         end else if (k < 16) begin
            if ($urandom_range(0, 3) == 0) add_str(pair_ops[$urandom_range(0, 3)]);
            else text_q.push_back(op_chars[$urandom_range(0, 11)]);
         end else if (k < 19) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(rand_blank());
         end else begin
            if ($urandom_range(0, 2) == 0) text_q.push_back(CH_BANG);
            else text_q.push_back(8'($urandom_range(1, 255)));
         end
         if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(rand_blank());
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            // every operator and keyword, number saturation, near-keywords
            add_str("if(x1<=42){return _Z9;}");
            send_text();
            add_str("else while!=for>=a==b+-*/<>;=");
            send_text();
            add_str("99999999999 xreturn\treturnx\n");
            send_text();
            // lone bang, a bad last byte after a word, a bad first byte
            add_str("a!b c");
            send_text();
            add_str("7");
            send_text();
            add_str("ab");
            text_q.push_back(8'hFF);
            send_text();
            add_str("!");
            send_text();
            text_q.push_back(8'h80);
            add_str("q 5");
            send_text();
            add_str("<=");
            send_text();

            while (live_items < TOTAL_ITEMS) begin
               add_random_text();
               send_text();
            end

            req_valid <= 1'b0;
            while (sb.expected.size() != 0) @(posedge clock);
            repeat (20) @(posedge clock);
         end
         begin
            wait (stall_cycles >= STALL_LIMIT);
            timed_out = 1'b1;
         end
      join_any
      disable fork;
      if (!timed_out && sb.fails == 0)
         $display("** c_subset_lexer: PASSED **");
      else
         $display("** c_subset_lexer: FAILED **");
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/csl_pkg.sv
design/c_subset_lexer.sv
tb/sv/tb_c_subset_lexer.sv
